>>> hw/rtl/slcfr_pkg.sv
package slcfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_CMP_W = 9;
  localparam int CMD_START = 4;

  localparam logic [BYTE_W-1:0] LEN_MIN = 8'd3;

  localparam logic [KIND_W-1:0] KIND_CMD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PONG = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CSUM = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OVER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SYNC = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LEN  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_CODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PONG_CODE   = 2'd3;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd85;
  localparam logic [BYTE_W-1:0] PING_CODE_RST   = 8'd0;
  localparam logic [BYTE_W-1:0] PONG_CODE_RST   = 8'd1;

  typedef enum logic [2:0] {
    ST_IN,
    ST_PONG1,
    ST_PONG2,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    CLS_STORE,
    CLS_SYNC,
    CLS_OVER,
    CLS_PONG,
    CLS_LEN,
    CLS_CSUM,
    CLS_BURST
  } cls_t;

  typedef enum logic [1:0] {
    OSEL_CLS,
    OSEL_PONG2,
    OSEL_PONG3,
    OSEL_BURST
  } osel_t;

  typedef struct packed {
    logic  accept;
    logic  out_load;
    osel_t out_sel;
    logic  burst_start;
    logic  burst_step;
    logic  burst_done;
  } ctrl_cmd_t;

  typedef struct packed {
    cls_t cls;
    logic burst_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hw/rtl/sync_length_checksum_frame_receiver_unit.sv
// A byte that ends in an error, or a ping that starts a pong, shows on out in the cycle after it is taken.
// One input beat per cycle while the output register is free; input is held off while the pong beats go out.
// A good frame end emits its command bytes from the frame store, each beat a registered
// store read and then an output load; input is held off until the last one is taken.
// Reset (rst_n low, synchronous): hunt restarts, output empties, config registers take defaults.
module sync_length_checksum_frame_receiver_unit #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [slcfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slcfr_pkg::BYTE_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [slcfr_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [slcfr_pkg::KIND_W-1:0]      out_result_kind,
  output logic [slcfr_pkg::BYTE_W-1:0]      out_byte,
  output logic                              out_last_of_run
);

  slcfr_pkg::ctrl_cmd_t cmd;
  slcfr_pkg::dp_stat_t  stat;

  slcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slcfr_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_rx_byte      (in_rx_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> hw/rtl/slcfr_ctrl.sv
module slcfr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  slcfr_pkg::dp_stat_t   stat,
  output slcfr_pkg::ctrl_cmd_t  cmd
);

  slcfr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slcfr_pkg::ST_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.out_load    = 1'b0;
    cmd.out_sel     = slcfr_pkg::OSEL_CLS;
    cmd.burst_start = 1'b0;
    cmd.burst_step  = 1'b0;
    cmd.burst_done  = 1'b0;
    unique case (state_r)
      slcfr_pkg::ST_IN: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.accept = 1'b1;
          priority if (stat.cls == slcfr_pkg::CLS_BURST) begin
            cmd.burst_start = 1'b1;
            state_nxt       = slcfr_pkg::ST_FETCH;
          end else if (stat.cls == slcfr_pkg::CLS_PONG) begin
            cmd.out_load = 1'b1;
            state_nxt    = slcfr_pkg::ST_PONG1;
          end else if (stat.cls != slcfr_pkg::CLS_STORE) begin
            cmd.out_load = 1'b1;
          end else begin
            state_nxt = slcfr_pkg::ST_IN;
          end
        end
      end
      slcfr_pkg::ST_PONG1: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = slcfr_pkg::OSEL_PONG2;
          state_nxt    = slcfr_pkg::ST_PONG2;
        end
      end
      slcfr_pkg::ST_PONG2: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = slcfr_pkg::OSEL_PONG3;
          state_nxt    = slcfr_pkg::ST_IN;
        end
      end
      slcfr_pkg::ST_FETCH: begin
        state_nxt = slcfr_pkg::ST_EMIT;
      end
      slcfr_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = slcfr_pkg::OSEL_BURST;
          if (stat.burst_last) begin
            cmd.burst_done = 1'b1;
            state_nxt      = slcfr_pkg::ST_IN;
          end else begin
            cmd.burst_step = 1'b1;
            state_nxt      = slcfr_pkg::ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = slcfr_pkg::ST_IN;
      end
    endcase
  end

endmodule

>>> hw/rtl/slcfr_dpath.sv
module slcfr_dpath #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [slcfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slcfr_pkg::BYTE_W-1:0]         cfg_data,
  input  logic [slcfr_pkg::BYTE_W-1:0]         in_rx_byte,
  input  slcfr_pkg::ctrl_cmd_t                 cmd,
  output slcfr_pkg::dp_stat_t                  stat,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [slcfr_pkg::KIND_W-1:0]         out_result_kind,
  output logic [slcfr_pkg::BYTE_W-1:0]         out_byte,
  output logic                                 out_last_of_run
);

  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  logic [slcfr_pkg::BYTE_W-1:0] sync_first_r, sync_second_r, ping_code_r, pong_code_r;
  logic [CNT_W-1:0]             count_r;
  logic [slcfr_pkg::BYTE_W-1:0] len_r, csum_r, sum_r;
  logic [IDX_W-1:0]             rd_ptr_r;
  logic [slcfr_pkg::BYTE_W-1:0] rd_data_r;
  logic [slcfr_pkg::BYTE_W-1:0] mem [STORE_DEPTH];

  logic                         out_valid_r;
  logic [slcfr_pkg::KIND_W-1:0] out_kind_r;
  logic [slcfr_pkg::BYTE_W-1:0] out_byte_r;
  logic                         out_last_r;

  logic [CNT_W-1:0]             cnt_inc;
  logic [slcfr_pkg::BYTE_W-1:0] sum_fin;
  logic                         frame_end;
  slcfr_pkg::cls_t              cls;
  logic                         keep;
  logic [slcfr_pkg::KIND_W-1:0] ld_kind;
  logic [slcfr_pkg::BYTE_W-1:0] ld_byte;
  logic                         ld_last;

  assign cnt_inc   = count_r + 1'b1;
  assign sum_fin   = sum_r + in_rx_byte;
  assign frame_end = (cnt_inc > CNT_W'(slcfr_pkg::CMD_START - 1)) &&
                     (slcfr_pkg::LEN_CMP_W'(cnt_inc) ==
                      slcfr_pkg::LEN_CMP_W'(len_r) + slcfr_pkg::LEN_CMP_W'(2));

  always_comb begin
    priority if (count_r == CNT_W'(0)) begin
      cls = (in_rx_byte == sync_first_r) ? slcfr_pkg::CLS_STORE : slcfr_pkg::CLS_SYNC;
    end else if (count_r == CNT_W'(1)) begin
      cls = (in_rx_byte == sync_second_r) ? slcfr_pkg::CLS_STORE : slcfr_pkg::CLS_SYNC;
    end else if (count_r >= CNT_W'(STORE_DEPTH)) begin
      cls = slcfr_pkg::CLS_OVER;
    end else if (count_r == CNT_W'(2) && in_rx_byte == ping_code_r) begin
      cls = slcfr_pkg::CLS_PONG;
    end else if (count_r == CNT_W'(2) && in_rx_byte < slcfr_pkg::LEN_MIN) begin
      cls = slcfr_pkg::CLS_LEN;
    end else if (frame_end) begin
      cls = (sum_fin == csum_r) ? slcfr_pkg::CLS_BURST : slcfr_pkg::CLS_CSUM;
    end else begin
      cls = slcfr_pkg::CLS_STORE;
    end
  end

  assign keep = (cls == slcfr_pkg::CLS_STORE) || (cls == slcfr_pkg::CLS_BURST);

  assign stat.cls        = cls;
  assign stat.burst_last = (CNT_W'(rd_ptr_r) + 1'b1) == count_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    ld_kind = slcfr_pkg::KIND_CMD;
    ld_byte = '0;
    ld_last = 1'b1;
    unique case (cmd.out_sel)
      slcfr_pkg::OSEL_CLS: begin
        unique case (cls)
          slcfr_pkg::CLS_SYNC: ld_kind = slcfr_pkg::KIND_SYNC;
          slcfr_pkg::CLS_OVER: ld_kind = slcfr_pkg::KIND_OVER;
          slcfr_pkg::CLS_LEN:  ld_kind = slcfr_pkg::KIND_LEN;
          slcfr_pkg::CLS_CSUM: ld_kind = slcfr_pkg::KIND_CSUM;
          slcfr_pkg::CLS_PONG: begin
            ld_kind = slcfr_pkg::KIND_PONG;
            ld_byte = sync_first_r;
            ld_last = 1'b0;
          end
          default: ld_kind = slcfr_pkg::KIND_CMD;
        endcase
      end
      slcfr_pkg::OSEL_PONG2: begin
        ld_kind = slcfr_pkg::KIND_PONG;
        ld_byte = sync_second_r;
        ld_last = 1'b0;
      end
      slcfr_pkg::OSEL_PONG3: begin
        ld_kind = slcfr_pkg::KIND_PONG;
        ld_byte = pong_code_r;
      end
      slcfr_pkg::OSEL_BURST: begin
        ld_byte = rd_data_r;
        ld_last = stat.burst_last;
      end
      default: ld_kind = slcfr_pkg::KIND_CMD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= slcfr_pkg::SYNC_FIRST_RST;
      sync_second_r <= slcfr_pkg::SYNC_SECOND_RST;
      ping_code_r   <= slcfr_pkg::PING_CODE_RST;
      pong_code_r   <= slcfr_pkg::PONG_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slcfr_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        slcfr_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_data;
        slcfr_pkg::CFG_PING_CODE:   ping_code_r   <= cfg_data;
        slcfr_pkg::CFG_PONG_CODE:   pong_code_r   <= cfg_data;
        default:                    pong_code_r   <= pong_code_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.accept) begin
      count_r <= keep ? cnt_inc : '0;
    end else if (cmd.burst_done) begin
      count_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && cls == slcfr_pkg::CLS_STORE) begin
      if (count_r == CNT_W'(2)) begin
        len_r <= in_rx_byte;
      end else if (count_r == CNT_W'(3)) begin
        csum_r <= in_rx_byte;
        sum_r  <= '0;
      end else begin
        sum_r <= sum_fin;
      end
    end
    if (cmd.accept && keep) begin
      mem[count_r[IDX_W-1:0]] <= in_rx_byte;
    end
    if (cmd.burst_start) begin
      rd_ptr_r <= IDX_W'(slcfr_pkg::CMD_START);
    end else if (cmd.burst_step) begin
      rd_ptr_r <= rd_ptr_r + 1'b1;
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= ld_kind;
      out_byte_r <= ld_byte;
      out_last_r <= ld_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

>>> hw/rtl/slcfr_chk.sv
module slcfr_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [slcfr_pkg::KIND_W-1:0]     out_result_kind,
  input logic [slcfr_pkg::BYTE_W-1:0]     out_byte,
  input logic                             out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
                                $stable(out_byte) && $stable(out_last_of_run))
    else $error("stalled out beat changed");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == slcfr_pkg::KIND_CSUM ||
                  out_result_kind == slcfr_pkg::KIND_OVER ||
                  out_result_kind == slcfr_pkg::KIND_SYNC ||
                  out_result_kind == slcfr_pkg::KIND_LEN)
      |-> out_byte == '0 && out_last_of_run)
    else $error("error beat with data or not last");

  a_run_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !in_ready)
    else $error("input taken in the middle of a run");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

endmodule

bind sync_length_checksum_frame_receiver_unit slcfr_chk u_slcfr_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_kind (out_result_kind),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);
